// File: hdl/command_reply_activity_detector_top_defines.svh
// Assertion macros for the command/reply activity detector
`ifndef COMMAND_REPLY_ACTIVITY_DETECTOR_TOP_DEFINES_SVH
`define COMMAND_REPLY_ACTIVITY_DETECTOR_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CRAD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CRAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/crad_pkg.sv
// Package: types and constants of the command/reply activity detector
package crad_pkg;

    localparam int TIME_W  = 32;
    localparam int LEN_W   = 16;
    localparam int BYTES_W = 32;
    localparam int PKTS_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [TIME_W-1:0]  MAX_INTERVAL_RESET = 32'd1000;
    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
    localparam logic [PKTS_W-1:0]  PKTS_MAX  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_INTERVAL = 3'd0,
        CFG_MUST_WAIT    = 3'd1,
        CFG_MIN_BYTES    = 3'd2,
        CFG_MIN_FLIPS    = 3'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [TIME_W-1:0]  max_interval_ms;
        logic               must_wait;
        logic [BYTES_W-1:0] min_bytes;
        logic [PKTS_W-1:0]  min_flips;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] timestamp_ms;
        logic              client_to_server;
        logic [LEN_W-1:0]  payload_length;
    } pkt_t;

endpackage

// File: hdl/crad_cfg.sv
// Configuration register file
module crad_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [crad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crad_pkg::CFG_DATA_W-1:0] cfg_data,
    output crad_pkg::cfg_t                  cfg
);
    import crad_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_INTERVAL: cfg_next.max_interval_ms = cfg_data[TIME_W-1:0];
                CFG_MUST_WAIT:    cfg_next.must_wait       = cfg_data[0];
                CFG_MIN_BYTES:    cfg_next.min_bytes       = cfg_data[BYTES_W-1:0];
                CFG_MIN_FLIPS:    cfg_next.min_flips       = cfg_data[PKTS_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_interval_ms <= MAX_INTERVAL_RESET;
            cfg_reg.must_wait       <= 1'b0;
            cfg_reg.min_bytes       <= '0;
            cfg_reg.min_flips       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/crad_in_stage.sv
// Input register stage: holds one accepted packet until it is processed
module crad_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  crad_pkg::pkt_t pkt,
    input  logic           advance,
    output logic           stage_valid,
    output crad_pkg::pkt_t stage_pkt
);
    import crad_pkg::*;

    logic valid_reg;
    logic valid_next;
    pkt_t pkt_reg;

    // a held item leaving this cycle frees the slot for the next one
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            pkt_reg <= pkt;
    end

    assign stage_valid = valid_reg;
    assign stage_pkt   = pkt_reg;

endmodule

// File: hdl/crad_tracker.sv
// Flow state tracker: command open/close, reply counters and detection
module crad_tracker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  crad_pkg::pkt_t pkt,
    input  crad_pkg::cfg_t cfg,
    output logic           detected_next
);
    import crad_pkg::*;

    logic [TIME_W-1:0]  prev_time_reg,    prev_time_next;
    logic               prev_dir_reg,     prev_dir_next;
    logic               req_open_reg,     req_open_next;
    logic               waited_reg,       waited_next;
    logic [BYTES_W-1:0] reply_bytes_reg,  reply_bytes_next;
    logic [PKTS_W-1:0]  reply_pkts_reg,   reply_pkts_next;

    logic [TIME_W-1:0]  gap;
    logic               has_data;
    logic               open_cmd;
    logic [BYTES_W:0]   bytes_sum;

    assign gap       = pkt.timestamp_ms - prev_time_reg;
    assign has_data  = pkt.payload_length != '0;
    assign open_cmd  = pkt.client_to_server && has_data;
    assign bytes_sum = {1'b0, reply_bytes_reg} + {{(BYTES_W + 1 - LEN_W){1'b0}}, pkt.payload_length};

    always_comb
    begin
        prev_time_next   = pkt.timestamp_ms;
        prev_dir_next    = pkt.client_to_server;
        req_open_next    = req_open_reg;
        waited_next      = waited_reg;
        reply_bytes_next = reply_bytes_reg;
        reply_pkts_next  = reply_pkts_reg;

        if (req_open_reg)
        begin
            if (open_cmd || gap >= cfg.max_interval_ms)
            begin
                req_open_next = 1'b0;
            end
            else if (!pkt.client_to_server)
            begin
                // empty server packet right after the command, before any reply
                if (prev_dir_reg && !has_data && reply_bytes_reg == '0)
                begin
                    waited_next = 1'b1;
                end
                else
                begin
                    reply_bytes_next = bytes_sum[BYTES_W] ? BYTES_MAX : bytes_sum[BYTES_W-1:0];
                    if (reply_pkts_reg != PKTS_MAX)
                        reply_pkts_next = reply_pkts_reg + 1'b1;
                end
            end
        end

        if (!req_open_next && open_cmd)
        begin
            req_open_next    = 1'b1;
            waited_next      = 1'b0;
            reply_bytes_next = '0;
            reply_pkts_next  = '0;
        end

        detected_next = (waited_next || !cfg.must_wait) &&
                        reply_bytes_next >= cfg.min_bytes &&
                        reply_pkts_next >= cfg.min_flips;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg   <= '0;
            prev_dir_reg    <= 1'b0;
            req_open_reg    <= 1'b0;
            waited_reg      <= 1'b0;
            reply_bytes_reg <= '0;
            reply_pkts_reg  <= '0;
        end
        else if (advance)
        begin
            prev_time_reg   <= prev_time_next;
            prev_dir_reg    <= prev_dir_next;
            req_open_reg    <= req_open_next;
            waited_reg      <= waited_next;
            reply_bytes_reg <= reply_bytes_next;
            reply_pkts_reg  <= reply_pkts_next;
        end
    end

endmodule

// File: hdl/command_reply_activity_detector_top.sv
// Top level of the command/reply activity detector
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------------
//  in       | in_valid / in_ready  | timestamp_ms, client_to_server, payload_length
//  out      | out_valid / out_ready| detected
//  cfg      | cfg_we               | cfg_index, cfg_data
//
// One item per cycle sustained while out_ready is high; an item reaches out_valid
// through the input register, then the state update into the result register.
// Reset is async, active low; control state clears at once, no clearing pass.
// A held result stalls the tracker; the input register still takes one more item.
module command_reply_activity_detector_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [crad_pkg::TIME_W-1:0]     timestamp_ms,
    input  logic                            client_to_server,
    input  logic [crad_pkg::LEN_W-1:0]      payload_length,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            detected,
    input  logic                            cfg_we,
    input  logic [crad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crad_pkg::CFG_DATA_W-1:0] cfg_data
);
    import crad_pkg::*;

`include "command_reply_activity_detector_top_defines.svh"

    cfg_t cfg;
    pkt_t in_pkt;
    pkt_t stage_pkt;
    logic stage_valid;
    logic advance;
    logic detected_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic detected_reg;

    assign in_pkt.timestamp_ms     = timestamp_ms;
    assign in_pkt.client_to_server = client_to_server;
    assign in_pkt.payload_length   = payload_length;

    crad_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crad_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pkt         (in_pkt),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_pkt   (stage_pkt)
    );

    // the held item moves on when the result register is free or being emptied
    assign advance = stage_valid && (!out_valid_reg || out_ready);

    crad_tracker u_tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .pkt           (stage_pkt),
        .cfg           (cfg),
        .detected_next (detected_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            detected_reg <= detected_next;
    end

    assign out_valid = out_valid_reg;
    assign detected  = detected_reg;

    `CRAD_ASSERT_NEXT(a_no_phantom_result, clk, rst_n, !out_valid && !advance, !out_valid, "result appeared without an item")
    `CRAD_ASSERT_NEXT(a_held_item_kept, clk, rst_n, stage_valid && !advance, stage_valid, "held item lost")
    `CRAD_ASSERT_NEXT(a_no_threshold_detects, clk, rst_n, advance && !cfg.must_wait && cfg.min_bytes == '0 && cfg.min_flips == '0, detected, "zero thresholds must detect")

endmodule

// File: tb/sv/crad_activity_checker.sv
// Checker for the command/reply activity detector: tracks flow state and compares each result
module crad_activity_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [crad_pkg::TIME_W-1:0]     timestamp_ms,
    input  logic                            client_to_server,
    input  logic [crad_pkg::LEN_W-1:0]      payload_length,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            detected,
    input  logic                            cfg_we,
    input  logic [crad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crad_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              items_in,
    output int                              items_out,
    output int                              mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import crad_pkg::*;

    cfg_t               regs;
    logic [TIME_W-1:0]  last_ts;
    logic               last_dir;
    logic               cmd_open;
    logic               waited;
    logic [BYTES_W-1:0] reply_bytes;
    logic [PKTS_W-1:0]  reply_pkts;

    logic detected_q[$];
    logic want;

    // Apply one packet to the flow state and return the detection flag after it
    function automatic logic apply_packet(input logic [TIME_W-1:0] ts, input logic c2s,
                                          input logic [LEN_W-1:0] len);
        logic [TIME_W-1:0] gap;
        logic              was_c2s;
        logic              has_data;
        logic [BYTES_W:0]  sum;
        gap      = ts - last_ts;
        was_c2s  = last_dir;
        has_data = (len != '0);
        last_ts  = ts;
        last_dir = c2s;
        if (cmd_open)
        begin
            if (c2s && has_data)
            begin
                cmd_open = 1'b0;
            end
            else if (gap >= regs.max_interval_ms)
            begin
                cmd_open = 1'b0;
            end
            else if (!c2s)
            begin
                // empty server packet right after the command, nothing replied yet
                if (was_c2s && !has_data && reply_bytes == '0)
                begin
                    waited = 1'b1;
                end
                else
                begin
                    sum = {1'b0, reply_bytes} + {{(BYTES_W + 1 - LEN_W){1'b0}}, len};
                    reply_bytes = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];
                    if (reply_pkts != PKTS_MAX)
                        reply_pkts = reply_pkts + 1'b1;
                end
            end
        end
        if (!cmd_open && c2s && has_data)
        begin
            cmd_open    = 1'b1;
            waited      = 1'b0;
            reply_bytes = '0;
            reply_pkts  = '0;
        end
        return (waited || !regs.must_wait) && reply_bytes >= regs.min_bytes &&
               reply_pkts >= regs.min_flips;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.max_interval_ms <= MAX_INTERVAL_RESET;
            regs.must_wait       <= 1'b0;
            regs.min_bytes       <= '0;
            regs.min_flips       <= '0;
            last_ts     = '0;
            last_dir    = 1'b0;
            cmd_open    = 1'b0;
            waited      = 1'b0;
            reply_bytes = '0;
            reply_pkts  = '0;
            detected_q.delete();
            items_in   <= 0;
            items_out  <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (detected_q.size() == 0)
                begin
                    $error("detected: no item expected, actual %0b", detected);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = detected_q.pop_front();
                    if (want !== detected)
                    begin
                        $error("detected: expected %0b, actual %0b", want, detected);
                        mismatches <= mismatches + 1;
                    end
                end
                items_out <= items_out + 1;
            end
            if (in_valid && in_ready)
            begin
                detected_q.push_back(apply_packet(timestamp_ms, client_to_server,
                                                  payload_length));
                items_in <= items_in + 1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_INTERVAL: regs.max_interval_ms <= cfg_data[TIME_W-1:0];
                    CFG_MUST_WAIT:    regs.must_wait       <= cfg_data[0];
                    CFG_MIN_BYTES:    regs.min_bytes       <= cfg_data[BYTES_W-1:0];
                    CFG_MIN_FLIPS:    regs.min_flips       <= cfg_data[PKTS_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

endmodule

// File: tb/sv/tb_command_reply_activity_detector_top.sv
// Testbench top: packet stimulus, register settings and verdict for the activity detector
module tb_command_reply_activity_detector_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crad_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
    localparam int HOLD_CYCLES = 200;

    logic                  clk;
    logic                  rst_n            = 1'b0;
    logic                  in_valid         = 1'b0;
    logic                  in_ready;
    logic [TIME_W-1:0]     timestamp_ms     = '0;
    logic                  client_to_server = 1'b0;
    logic [LEN_W-1:0]      payload_length   = '0;
    logic                  out_valid;
    logic                  out_ready        = 1'b0;
    logic                  detected;
    logic                  cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index        = '0;
    logic [CFG_DATA_W-1:0] cfg_data         = '0;

    int items_in;
    int items_out;
    int mismatches;

    int                sent        = 0;
    int                settings    = 0;
    logic [TIME_W-1:0] now_ms      = '0;
    logic [TIME_W-1:0] cur_interval = MAX_INTERVAL_RESET;
    bit                tx_idle_on  = 1'b0;
    bit                rx_idle_on  = 1'b0;
    bit                rx_hold     = 1'b0;

    command_reply_activity_detector_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .timestamp_ms     (timestamp_ms),
        .client_to_server (client_to_server),
        .payload_length   (payload_length),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .detected         (detected),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    crad_activity_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .timestamp_ms     (timestamp_ms),
        .client_to_server (client_to_server),
        .payload_length   (payload_length),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .detected         (detected),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .items_in         (items_in),
        .items_out        (items_out),
        .mismatches       (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(8_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial
    begin
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (rx_hold)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_pkt(input logic [TIME_W-1:0] ts, input logic c2s,
                            input logic [LEN_W-1:0] len);
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid         <= 1'b1;
        timestamp_ms     <= ts;
        client_to_server <= c2s;
        payload_length   <= len;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    // stop offering items and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (items_in != items_out) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [TIME_W-1:0] interval, input logic wait_req,
                             input logic [BYTES_W-1:0] bytes_min,
                             input logic [PKTS_W-1:0] flips_min);
        drain();
        write_reg(CFG_MAX_INTERVAL, interval);
        write_reg(CFG_MUST_WAIT, {{(CFG_DATA_W-1){1'b0}}, wait_req});
        write_reg(CFG_MIN_BYTES, bytes_min);
        write_reg(CFG_MIN_FLIPS, {{(CFG_DATA_W-PKTS_W){1'b0}}, flips_min});
        cur_interval = interval;
        settings++;
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return LEN_W'($urandom_range(1, 1500));
            default: return LEN_W'($urandom);
        endcase
    endfunction

    // next timestamp: mostly inside the interval, sometimes past it, rarely a random jump
    function automatic logic [TIME_W-1:0] advance(input bit late);
        logic [TIME_W-1:0] cap;
        if ($urandom_range(0, 40) == 0)
        begin
            now_ms = $urandom;
        end
        else if (late)
        begin
            now_ms = now_ms + cur_interval + $urandom_range(0, 50);
        end
        else if (cur_interval > 1)
        begin
            cap = (cur_interval - 1 > 3000) ? TIME_W'(3000) : cur_interval - 1;
            now_ms = now_ms + $urandom_range(0, cap);
        end
        return now_ms;
    endfunction

    // one client command with its replies, or a short burst of noise
    task automatic run_command();
        int               replies;
        bit               late;
        logic [LEN_W-1:0] cmd_len;
        if ($urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 4))
                send_pkt($urandom, 1'($urandom_range(0, 1)), pick_len());
        end
        else
        begin
            cmd_len = pick_len();
            if (cmd_len == '0)
                cmd_len = LEN_W'(1);
            send_pkt(advance($urandom_range(0, 7) == 0), 1'b1, cmd_len);
            if ($urandom_range(0, 1))
                send_pkt(advance(1'b0), 1'b0, '0);
            replies = $urandom_range(0, 8);
            for (int k = 0; k < replies; k++)
            begin
                late = ($urandom_range(0, 15) == 0);
                if ($urandom_range(0, 7) == 0)
                    send_pkt(advance(late), 1'b1, '0);
                else
                    send_pkt(advance(late), 1'b0, pick_len());
            end
        end
    endtask

    task automatic run_items(input int count, input bit allow_idle);
        int stop;
        stop = sent + count;
        while (sent < stop)
        begin
            if (allow_idle && $urandom_range(0, 9) == 0)
                tx_idle_on = $urandom_range(0, 2) != 0;
            if (allow_idle && $urandom_range(0, 9) == 0)
                rx_idle_on = $urandom_range(0, 2) != 0;
            run_command();
        end
    endtask

    task automatic random_settings(input int phase);
        logic [TIME_W-1:0]  interval;
        logic [BYTES_W-1:0] bytes_min;
        logic [PKTS_W-1:0]  flips_min;
        case (phase % 5)
            0:       interval = '0;
            1:       interval = $urandom_range(1, 20);
            2:       interval = MAX_INTERVAL_RESET;
            3:       interval = $urandom;
            default: interval = '1;
        endcase
        case ($urandom_range(0, 3))
            0:       bytes_min = '0;
            3:       bytes_min = $urandom;
            default: bytes_min = $urandom_range(1, 4000);
        endcase
        case ($urandom_range(0, 3))
            0:       flips_min = '0;
            3:       flips_min = PKTS_W'($urandom);
            default: flips_min = PKTS_W'($urandom_range(1, 5));
        endcase
        configure(interval, 1'($urandom_range(0, 1)), bytes_min, flips_min);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: interval stays at its reset value
        write_reg(CFG_MUST_WAIT, 32'd1);
        write_reg(CFG_MIN_BYTES, 32'd1);
        write_reg(CFG_MIN_FLIPS, 32'd2);
        settings++;
        send_pkt(32'd5, 1'b0, 16'd0);        // empty server packet, nothing open
        send_pkt(32'd10, 1'b1, 16'd100);     // command opens
        send_pkt(32'd20, 1'b0, 16'd0);       // server waited
        send_pkt(32'd30, 1'b0, 16'hFFFF);
        send_pkt(32'd40, 1'b1, 16'd0);       // empty client packet while open
        send_pkt(32'd50, 1'b0, 16'd0);       // empty, but bytes already counted
        send_pkt(32'd1050, 1'b0, 16'd10);    // gap equals interval: timeout, values kept
        send_pkt(32'd1060, 1'b1, 16'd1);
        send_pkt(32'd1061, 1'b0, 16'd5);
        send_pkt(32'd1062, 1'b1, 16'd0);
        send_pkt(32'd1063, 1'b0, 16'd0);
        send_pkt(32'd2062, 1'b0, 16'd1);     // one below the interval
        send_pkt(32'hFFFF_FFF0, 1'b1, 16'hFFFF);
        send_pkt(32'h0000_0005, 1'b0, 16'd0); // gap wraps past zero
        send_pkt(32'd6, 1'b0, 16'd200);
        send_pkt(32'd7, 1'b0, 16'd300);
        send_pkt(32'd7, 1'b1, 16'd50);
        drain();
        write_reg(CFG_MAX_INTERVAL, 32'd0);
        cur_interval = '0;
        settings++;
        send_pkt(32'd7, 1'b0, 16'd0);        // zero interval closes at once
        send_pkt(32'd8, 1'b1, 16'd9);
        send_pkt(32'd8, 1'b1, 16'd10);       // new command replaces open one
        drain();
        write_reg(CFG_UNUSED, '1);           // must be ignored
        send_pkt(32'd9, 1'b0, 16'd4);
        send_pkt(32'd9, 1'b1, 16'd3);

        for (int p = 0; p < 5; p++)
        begin
            random_settings(p);
            tx_idle_on = 1'b1;
            rx_idle_on = 1'b1;
            if (p == 2)
            begin
                rx_hold = 1'b1;
                run_items(16, 1'b0);
                drain();
            end
            run_items(60, 1'b1);
            drain();
            run_items(60, 1'b1);
        end

        random_settings($urandom_range(0, 4));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_items(60, 1'b0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (items_in != items_out) @(posedge clk);
        repeat (6) @(posedge clk);

        $display("Run: %0d packets over %0d register settings, with timeouts, wrapped gaps,",
                 sent, settings);
        $display("  long output hold-off and unused register writes; %0d results, %0d mismatches",
                 items_out, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/crad_pkg.sv
hdl/crad_cfg.sv
hdl/crad_in_stage.sv
hdl/crad_tracker.sv
hdl/command_reply_activity_detector_top.sv
tb/sv/crad_activity_checker.sv
tb/sv/tb_command_reply_activity_detector_top.sv
